### rtl/core/lda_collapsed_gibbs_sampler_defines.svh
// Assertion macros shared by the sampler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LDA_COLLAPSED_GIBBS_SAMPLER_DEFINES_SVH
`define LDA_COLLAPSED_GIBBS_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sampler assertion failed");

// Next-cycle implication, disabled during reset.
`define LDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sampler assertion failed");

`endif

### rtl/core/lda_pkg.sv
// Shared constants, codes and state type of the sampler.
// No dependencies.
package lda_pkg;

    localparam int TOPIC_BITS  = 6;
    localparam int TOPICS      = 64;
    localparam int WORD_BITS   = 12;
    localparam int DOC_BITS    = 12;
    localparam int COUNT_BITS  = 24;
    localparam int FRAC_BITS   = 16;
    localparam int FACT_BITS   = COUNT_BITS + FRAC_BITS;
    localparam int HALF_BITS   = FACT_BITS / 2;
    localparam int PROD_BITS   = 2 * FACT_BITS;
    localparam int DEN_BITS    = FACT_BITS + 1;
    localparam int REM_BITS    = DEN_BITS + 1;
    localparam int WEIGHT_BITS = 48;
    localparam int SUM_BITS    = WEIGHT_BITS + TOPIC_BITS;
    localparam int VB_BITS     = 29;
    localparam int RAND_BITS   = 32;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int TIU_BITS    = 7;
    localparam int VOCAB_BITS  = 13;
    localparam int STEP_BITS   = 7;

    localparam logic [2:0] FN_WR_WORD  = 3'd0;
    localparam logic [2:0] FN_WR_DOC   = 3'd1;
    localparam logic [2:0] FN_WR_TOTAL = 3'd2;
    localparam logic [2:0] FN_SAMPLE   = 3'd3;
    localparam logic [2:0] FN_RD_WORD  = 3'd4;
    localparam logic [2:0] FN_RD_DOC   = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BETA   = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOCAB  = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOPICS = 8'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_WRITE, S_READ, S_READ_WAIT, S_UPD_RD, S_UPD_WR,
        S_W_RD, S_W_LD, S_W_MUL, S_W_DIV, S_W_ST,
        S_THR1, S_THR2, S_SC_RD, S_SC_CHK, S_DONE
    } state_t;

endpackage

### rtl/core/lda_smp_if.sv
// Input item channel of the sampler.
// Depends on lda_pkg.
interface lda_smp_if;
    import lda_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [2:0]              func;
    logic [WORD_BITS-1:0]    word_index;
    logic [DOC_BITS-1:0]     doc_index;
    logic [TOPIC_BITS-1:0]   topic;
    logic [COUNT_BITS-1:0]   count_value;
    logic [RAND_BITS-1:0]    random_fraction;
    modport source (output valid, func, word_index, doc_index, topic, count_value,
                    random_fraction, input ready);
    modport sink (input valid, func, word_index, doc_index, topic, count_value,
                  random_fraction, output ready);
endinterface

### rtl/core/lda_res_if.sv
// Result channel of the sampler.
// Depends on lda_pkg.
interface lda_res_if;
    import lda_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [TOPIC_BITS-1:0]   new_topic;
    logic [COUNT_BITS-1:0]   read_count;
    modport source (output valid, new_topic, read_count, input ready);
    modport sink (input valid, new_topic, read_count, output ready);
endinterface

### rtl/core/lda_cfg_if.sv
// Configuration write channel of the sampler.
// Depends on lda_pkg.
interface lda_cfg_if;
    import lda_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/lda_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module lda_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/lda_collapsed_gibbs_sampler.sv
// Collapsed Gibbs sampler for LDA: count stores, weight engine, topic selection.
// Depends on lda_pkg, lda_smp_if, lda_res_if, lda_cfg_if, lda_ram and the defines header.
//
// Usage:
//   smp carries one item per transfer: a count write (word, doc, total), a count
//   read (word, doc) or a sample. res returns exactly one result per item.
//   cfg writes alpha, beta, vocabulary size and topics in use; it is always ready
//   and must only be used while the block is idle.
// Sequence (one item at a time):
//   a write passes S_WRITE and S_DONE; a read passes S_READ, S_READ_WAIT and S_DONE.
//   a sample does, per topic in use, one read of the three count stores, a 5-step
//   multiply over 20-bit halves (four partial products, each accumulated a step
//   later) and an 80-step restoring divider; then one weight-memory read per
//   topic scanned.
// Reset sets only control and the configuration defaults; the count stores hold no value
//   until software writes them.
// A stalled receiver holds the result in the output register; the next item is
//   still taken and runs until its own result would need that register.
`include "lda_collapsed_gibbs_sampler_defines.svh"
module lda_collapsed_gibbs_sampler (
    input  logic clk,
    input  logic rst_n,
    lda_smp_if.sink   smp,
    lda_res_if.source res,
    lda_cfg_if.sink   cfg
);
    import lda_pkg::*;

    localparam int WT_ADDR = TOPIC_BITS + WORD_BITS;
    localparam int DT_ADDR = TOPIC_BITS + DOC_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Saturating count step: add or remove one token.
    function automatic logic [COUNT_BITS-1:0] cnt_step(input logic [COUNT_BITS-1:0] c,
                                                      input logic inc);
        logic [COUNT_BITS-1:0] r;
        r = c;
        if (inc)
        begin
            if (c != CNT_MAX) r = c + 1'b1;
        end
        else
        begin
            if (c != '0) r = c - 1'b1;
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    // configuration
    logic [FRAC_BITS-1:0]  alpha_reg, beta_reg;
    logic [VOCAB_BITS-1:0] vocab_reg;
    logic [TIU_BITS-1:0]   tiu_reg;

    // latched item
    logic [2:0]            func_reg, func_next;
    logic [WORD_BITS-1:0]  w_reg, w_next;
    logic [DOC_BITS-1:0]   d_reg, d_next;
    logic [TOPIC_BITS-1:0] t_reg, t_next;
    logic [COUNT_BITS-1:0] val_reg, val_next;
    logic [RAND_BITS-1:0]  frac_reg, frac_next;
    logic [TOPIC_BITS-1:0] nt_last_reg, nt_last_next;
    logic [VB_BITS-1:0]    vb_reg, vb_next;

    // sampling datapath
    logic [TOPIC_BITS-1:0] k_reg, k_next;
    logic [TOPIC_BITS-1:0] upd_topic_reg, upd_topic_next;
    logic                  inc_reg, inc_next;
    logic [STEP_BITS-1:0]  cnt_reg, cnt_next;
    logic [FACT_BITS-1:0]  a_reg, a_next, b_reg, b_next;
    logic [DEN_BITS-1:0]   den_reg, den_next;
    logic [FACT_BITS-1:0]  pp_reg, pp_next;
    logic [1:0]            ppsel_reg, ppsel_next;
    logic [PROD_BITS-1:0]  acc_reg, acc_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [SUM_BITS-1:0]   thr_hi_reg, thr_hi_next;
    logic [2*RAND_BITS-1:0] thr_lo_reg, thr_lo_next;
    logic [SUM_BITS:0]     thr_reg, thr_next;
    logic [SUM_BITS-1:0]   run_reg, run_next;
    logic [TOPIC_BITS-1:0] sel_reg, sel_next;
    logic [COUNT_BITS-1:0] rd_reg, rd_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [TOPIC_BITS-1:0] out_topic_reg, out_topic_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;

    // memories
    logic [TOPIC_BITS-1:0]  ram_topic;
    logic                   wt_we, dt_we, tot_we, wgt_we;
    logic [COUNT_BITS-1:0]  wt_wdata, dt_wdata, tot_wdata;
    logic [COUNT_BITS-1:0]  wt_rdata, dt_rdata, tot_rdata;
    logic [WEIGHT_BITS-1:0] wgt_wdata, wgt_rdata;

    // combinational helpers
    logic                   smp_xfer;
    logic [REM_BITS-1:0]    rem_sh;
    logic [HALF_BITS-1:0]   mul_a, mul_b;
    logic [PROD_BITS-1:0]   pp_shift;
    logic [SUM_BITS-1:0]    run_sum;
    logic [DEN_BITS-1:0]    den_raw;

    assign smp.ready = (state_reg == S_IDLE);
    assign smp_xfer  = smp.valid && smp.ready;
    assign cfg.ready = 1'b1;

    assign res.valid      = out_valid_reg;
    assign res.new_topic  = out_topic_reg;
    assign res.read_count = out_count_reg;

    lda_ram #(.WIDTH(COUNT_BITS), .DEPTH(TOPICS * (2 ** WORD_BITS))) u_word_ram (
        .clk(clk), .we(wt_we), .addr({ram_topic, w_reg}), .wdata(wt_wdata), .rdata(wt_rdata)
    );
    lda_ram #(.WIDTH(COUNT_BITS), .DEPTH(TOPICS * (2 ** DOC_BITS))) u_doc_ram (
        .clk(clk), .we(dt_we), .addr({ram_topic, d_reg}), .wdata(dt_wdata), .rdata(dt_rdata)
    );
    lda_ram #(.WIDTH(COUNT_BITS), .DEPTH(TOPICS)) u_total_ram (
        .clk(clk), .we(tot_we), .addr(ram_topic), .wdata(tot_wdata), .rdata(tot_rdata)
    );
    lda_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(TOPICS)) u_weight_ram (
        .clk(clk), .we(wgt_we), .addr(k_reg), .wdata(wgt_wdata), .rdata(wgt_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 16'd6554;
            beta_reg  <= 16'd655;
            vocab_reg <= 13'd4096;
            tiu_reg   <= 7'd64;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_ALPHA:  alpha_reg <= cfg.data;
                CFG_BETA:   beta_reg  <= cfg.data;
                CFG_VOCAB:  vocab_reg <= cfg.data[VOCAB_BITS-1:0];
                CFG_TOPICS: tiu_reg   <= cfg.data[TIU_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        w_reg         <= w_next;
        d_reg         <= d_next;
        t_reg         <= t_next;
        val_reg       <= val_next;
        frac_reg      <= frac_next;
        nt_last_reg   <= nt_last_next;
        vb_reg        <= vb_next;
        k_reg         <= k_next;
        upd_topic_reg <= upd_topic_next;
        inc_reg       <= inc_next;
        cnt_reg       <= cnt_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        den_reg       <= den_next;
        pp_reg        <= pp_next;
        ppsel_reg     <= ppsel_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        sum_reg       <= sum_next;
        thr_hi_reg    <= thr_hi_next;
        thr_lo_reg    <= thr_lo_next;
        thr_reg       <= thr_next;
        run_reg       <= run_next;
        sel_reg       <= sel_next;
        rd_reg        <= rd_next;
        out_topic_reg <= out_topic_next;
        out_count_reg <= out_count_next;
    end

    // memory address topic: the item's own topic, the topic being weighed, or the
    // topic being updated
    always_comb
    begin
        ram_topic = t_reg;
        if (state_reg == S_W_RD)
        begin
            ram_topic = k_reg;
        end
        else if (state_reg == S_UPD_RD || state_reg == S_UPD_WR)
        begin
            ram_topic = upd_topic_reg;
        end
    end

    assign rem_sh   = {rem_reg[REM_BITS-2:0], acc_reg[PROD_BITS-1]};
    assign mul_a    = cnt_reg[1] ? a_reg[FACT_BITS-1:HALF_BITS] : a_reg[HALF_BITS-1:0];
    assign mul_b    = cnt_reg[0] ? b_reg[FACT_BITS-1:HALF_BITS] : b_reg[HALF_BITS-1:0];
    assign run_sum  = run_reg + SUM_BITS'(wgt_rdata);
    assign den_raw  = {1'b0, tot_rdata, {FRAC_BITS{1'b0}}} + DEN_BITS'(vb_reg);

    // align the registered partial product by the halves it came from
    always_comb
    begin
        case (ppsel_reg)
            2'd0:    pp_shift = PROD_BITS'(pp_reg);
            2'd3:    pp_shift = PROD_BITS'(pp_reg) << (2 * HALF_BITS);
            default: pp_shift = PROD_BITS'(pp_reg) << HALF_BITS;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        w_next         = w_reg;
        d_next         = d_reg;
        t_next         = t_reg;
        val_next       = val_reg;
        frac_next      = frac_reg;
        nt_last_next   = nt_last_reg;
        vb_next        = vb_reg;
        k_next         = k_reg;
        upd_topic_next = upd_topic_reg;
        inc_next       = inc_reg;
        cnt_next       = cnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        den_next       = den_reg;
        pp_next        = pp_reg;
        ppsel_next     = ppsel_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        thr_hi_next    = thr_hi_reg;
        thr_lo_next    = thr_lo_reg;
        thr_next       = thr_reg;
        run_next       = run_reg;
        sel_next       = sel_reg;
        rd_next        = rd_reg;
        out_topic_next = out_topic_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg;
        wt_we          = 1'b0;
        dt_we          = 1'b0;
        tot_we         = 1'b0;
        wgt_we         = 1'b0;
        wt_wdata       = val_reg;
        dt_wdata       = val_reg;
        tot_wdata      = val_reg;
        wgt_wdata      = (|acc_reg[PROD_BITS-1:WEIGHT_BITS]) ? '1 : acc_reg[WEIGHT_BITS-1:0];

        // drop the result once the receiver takes it
        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (smp_xfer)
                begin
                    func_next      = smp.func;
                    w_next         = smp.word_index;
                    d_next         = smp.doc_index;
                    t_next         = smp.topic;
                    val_next       = smp.count_value;
                    frac_next      = smp.random_fraction;
                    vb_next        = VB_BITS'(vocab_reg * beta_reg);
                    rd_next        = '0;
                    upd_topic_next = smp.topic;
                    inc_next       = 1'b0;
                    if (tiu_reg == '0)
                    begin
                        nt_last_next = '0;
                    end
                    else if (tiu_reg > TIU_BITS'(TOPICS))
                    begin
                        nt_last_next = TOPIC_BITS'(TOPICS - 1);
                    end
                    else
                    begin
                        nt_last_next = TOPIC_BITS'(tiu_reg - 1'b1);
                    end
                    case (smp.func) inside
                        FN_WR_WORD, FN_WR_DOC, FN_WR_TOTAL: state_next = S_WRITE;
                        FN_RD_WORD, FN_RD_DOC:              state_next = S_READ;
                        FN_SAMPLE:                          state_next = S_UPD_RD;
                        default:                            state_next = S_DONE;
                    endcase
                end
            end
            S_WRITE:
            begin
                wt_we      = (func_reg == FN_WR_WORD);
                dt_we      = (func_reg == FN_WR_DOC);
                tot_we     = (func_reg == FN_WR_TOTAL);
                state_next = S_DONE;
            end
            S_READ:
            begin
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                rd_next    = (func_reg == FN_RD_WORD) ? wt_rdata : dt_rdata;
                state_next = S_DONE;
            end
            S_UPD_RD:
            begin
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                // remove or add back the token in all three stores
                wt_we     = 1'b1;
                dt_we     = 1'b1;
                tot_we    = 1'b1;
                wt_wdata  = cnt_step(wt_rdata, inc_reg);
                dt_wdata  = cnt_step(dt_rdata, inc_reg);
                tot_wdata = cnt_step(tot_rdata, inc_reg);
                if (inc_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = '0;
                    sum_next   = '0;
                    state_next = S_W_RD;
                end
            end
            S_W_RD:
            begin
                state_next = S_W_LD;
            end
            S_W_LD:
            begin
                a_next     = {wt_rdata, {FRAC_BITS{1'b0}}} + FACT_BITS'(beta_reg);
                b_next     = {dt_rdata, {FRAC_BITS{1'b0}}} + FACT_BITS'(alpha_reg);
                den_next   = (den_raw == '0) ? DEN_BITS'(1) : den_raw;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_W_MUL;
            end
            S_W_MUL:
            begin
                // one partial product per step, accumulated a step later
                pp_next    = FACT_BITS'(mul_a * mul_b);
                ppsel_next = cnt_reg[1:0];
                if (cnt_reg != '0)
                begin
                    acc_next = acc_reg + pp_shift;
                end
                if (cnt_reg == STEP_BITS'(4))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = S_W_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_W_DIV:
            begin
                // restoring division: quotient bits shift in as dividend bits shift out
                if (rem_sh >= REM_BITS'(den_reg))
                begin
                    rem_next = rem_sh - REM_BITS'(den_reg);
                    acc_next = {acc_reg[PROD_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    acc_next = {acc_reg[PROD_BITS-2:0], 1'b0};
                end
                if (cnt_reg == STEP_BITS'(PROD_BITS - 1))
                begin
                    state_next = S_W_ST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_W_ST:
            begin
                wgt_we   = 1'b1;
                sum_next = sum_reg + SUM_BITS'(wgt_wdata);
                if (k_reg == nt_last_reg)
                begin
                    state_next = S_THR1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_W_RD;
                end
            end
            S_THR1:
            begin
                thr_hi_next = SUM_BITS'(sum_reg[SUM_BITS-1:RAND_BITS] * frac_reg);
                thr_lo_next = sum_reg[RAND_BITS-1:0] * frac_reg;
                state_next  = S_THR2;
            end
            S_THR2:
            begin
                thr_next   = (SUM_BITS + 1)'(thr_hi_reg)
                           + (SUM_BITS + 1)'(thr_lo_reg[2*RAND_BITS-1:RAND_BITS]);
                k_next     = '0;
                run_next   = '0;
                state_next = S_SC_RD;
            end
            S_SC_RD:
            begin
                state_next = S_SC_CHK;
            end
            S_SC_CHK:
            begin
                run_next = run_sum;
                if (({1'b0, run_sum} >= thr_reg) || (k_reg == nt_last_reg))
                begin
                    sel_next       = k_reg;
                    upd_topic_next = k_reg;
                    inc_next       = 1'b1;
                    state_next     = S_UPD_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SC_RD;
                end
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_topic_next = (func_reg == FN_SAMPLE) ? sel_reg : t_reg;
                    out_count_next = rd_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `LDA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, smp_xfer, state_reg != S_IDLE)
    `LDA_ASSERT_NOW(a_weigh_in_range, clk, rst_n, state_reg == S_W_RD, k_reg <= nt_last_reg)
    `LDA_ASSERT_NOW(a_add_back_in_range, clk, rst_n,
        (state_reg == S_UPD_WR) && inc_reg, upd_topic_reg <= nt_last_reg)
    `LDA_ASSERT_NEXT(a_done_waits, clk, rst_n,
        (state_reg == S_DONE) && out_valid_reg && !res.ready, state_reg == S_DONE)
endmodule
